/* design/tsq_pkg.sv */
package tsq_pkg;

  localparam int DEPTH = 128;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [DW-1:0] word_t;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNF = 2'd2;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

endpackage

/* design/tsq_ram.sv */
module tsq_ram (
  input  logic           clk,
  input  logic           we,
  input  tsq_pkg::addr_t waddr,
  input  tsq_pkg::word_t wdata,
  input  tsq_pkg::addr_t raddr,
  output tsq_pkg::word_t rdata
);

  tsq_pkg::word_t mem [tsq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/two_stack_fifo_queue_unit.sv */
// Enqueue, overflow and underflow results are registered in the accept cycle.
// A dequeue from a non-empty output stack issues the RAM read on accept and registers the word in S_READ.
// A dequeue that finds the output stack empty first moves the input stack across in S_MOVE,
// one RAM read and one RAM write per cycle, then passes through S_POP and S_READ.
// Enqueues can be taken every cycle while out_ready is high; a dequeue holds in_ready low until its result is set.
// Reset (rst_n low, synchronous) clears both counts, the state and the output valid.
module two_stack_fifo_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value_out,
  output logic [1:0]         out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]     state_r, state_nxt;
  tsq_pkg::cnt_t  in_cnt_r, in_cnt_nxt;
  tsq_pkg::cnt_t  out_cnt_r, out_cnt_nxt;
  logic           pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  tsq_pkg::word_t out_value_r, out_value_nxt;
  logic [1:0]     out_status_r, out_status_nxt;

  tsq_pkg::cnt_t  in_cnt_m1, out_cnt_m1;
  logic           accept;
  logic           in_we, out_we;
  tsq_pkg::word_t in_rdata, out_rdata;

  assign in_cnt_m1  = in_cnt_r - 1'b1;
  assign out_cnt_m1 = out_cnt_r - 1'b1;

  // The output register is free (or being emptied) whenever an item is taken.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign in_we  = accept && (in_op == tsq_pkg::OP_ENQ) && (in_cnt_r < tsq_pkg::DEPTH_CNT);
  assign out_we = (state_r == S_MOVE) && pend_r;

  tsq_ram u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_cnt_r[tsq_pkg::AW-1:0]),
    .wdata (in_value),
    .raddr (in_cnt_m1[tsq_pkg::AW-1:0]),
    .rdata (in_rdata)
  );

  tsq_ram u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_cnt_r[tsq_pkg::AW-1:0]),
    .wdata (in_rdata),
    .raddr (out_cnt_m1[tsq_pkg::AW-1:0]),
    .rdata (out_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    in_cnt_nxt     = in_cnt_r;
    out_cnt_nxt    = out_cnt_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == tsq_pkg::OP_ENQ) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            if (in_cnt_r < tsq_pkg::DEPTH_CNT) begin
              in_cnt_nxt     = in_cnt_r + 1'b1;
              out_status_nxt = tsq_pkg::ST_OK;
            end else begin
              out_status_nxt = tsq_pkg::ST_OVF;
            end
          end else if (in_cnt_r == '0 && out_cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = tsq_pkg::ST_UNF;
          end else if (out_cnt_r == '0) begin
            state_nxt = S_MOVE;
          end else begin
            // The RAM read of the top entry was issued at out_cnt_r - 1 this cycle.
            out_cnt_nxt = out_cnt_m1;
            state_nxt   = S_READ;
          end
        end
      end
      S_MOVE: begin
        // Read the input top each cycle; write last cycle's word to the output stack.
        if (in_cnt_r != '0) begin
          in_cnt_nxt = in_cnt_m1;
          pend_nxt   = 1'b1;
        end else begin
          state_nxt = S_POP;
        end
        if (pend_r) begin
          out_cnt_nxt = out_cnt_r + 1'b1;
        end
      end
      S_POP: begin
        out_cnt_nxt = out_cnt_m1;
        state_nxt   = S_READ;
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = out_rdata;
        out_status_nxt = tsq_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cnt_r <= tsq_pkg::DEPTH_CNT) && (out_cnt_r <= tsq_pkg::DEPTH_CNT))
    else $error("stack count beyond depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("output register busy when popped word arrives");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != tsq_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");

  a_move_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_MOVE) |-> (out_cnt_r == '0 && in_cnt_r != '0))
    else $error("transfer started with output stack not empty");

endmodule
